FILE: hw/rtl/rrt_tree_extend_assert.svh
// assertion macros for the tree extend block
// expects i_clk and i_rst_n in the scope of use
`ifndef RRT_TREE_EXTEND_ASSERT_SVH
`define RRT_TREE_EXTEND_ASSERT_SVH

// condition holds at every edge out of reset
`define RTE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("invariant violated");

// consequent holds in the cycle after the antecedent
`define RTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property violated");

`endif

FILE: hw/rtl/rte_pkg.sv
// shared types and constants of the tree extend block
// no dependencies
package rte_pkg;

    localparam int RTE_MAX_NODES = 1024;
    localparam int RTE_FRAC_BITS = 10;
    localparam int AW            = 5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BLOCKED = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_BADIDX  = 3'd5;

    localparam logic OP_EXTEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic [9:0]         node_select;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [9:0]         node_index;
        logic signed [15:0] node_x;
        logic signed [15:0] node_y;
        logic [9:0]         parent_index;
        logic               goal_reached;
    } t_rsp;

endpackage

FILE: hw/rtl/rte_chan.sv
// valid/ready channel carrying one payload
// payload type comes from rte_pkg at the instance
interface rte_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rrt_tree_extend.sv
// Planar tree growth engine. A request with op extend brings a sample point;
// the engine scans every stored node (root first) through a single-port node
// memory with a registered read, keeps the nearest by squared distance (ties
// to the lowest index), takes a bit-serial square root and two parallel
// restoring dividers (47 quotient bits after a load step) to build a
// fixed-length step, saturates, checks three clearance-grown boxes and
// appends the node unless it lies in one. An extend not cut short moves
// through the scan, root, multiply, divide, add, check, final and emit
// states in order; a read moves through a read-wait state and emit. A
// response waits in emit while the output register is full. One request is
// in flight at a time; a finished response sits in an output register so
// the next request is accepted while it waits. Node 0 always reflects the
// live root registers. Stores need no clearing pass: entries are only used
// below the node count. The user must see that registers are written over
// APB only while the engine is idle; the block itself does not enforce it.
// depends on rte_pkg, rte_chan and rrt_tree_extend_assert.svh
`include "rrt_tree_extend_assert.svh"

module rrt_tree_extend #(
    parameter int MAX_NODES = rte_pkg::RTE_MAX_NODES,
    parameter int FRAC_BITS = rte_pkg::RTE_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rte_chan.sink                 i_req,
    rte_chan.source               o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [rte_pkg::AW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import rte_pkg::*;

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int TW = NW + 1;
    localparam int BW = (FRAC_BITS + 4 > 18) ? FRAC_BITS + 4 : 18;
    localparam int EW = 32 + NW;
    localparam int RW = $bits(t_rsp);

    // obstacle geometry
    localparam logic signed [BW-1:0] OB_C  = BW'(2 ** (FRAC_BITS + 1));
    localparam logic signed [BW-1:0] OB_HX = BW'(3 * (2 ** FRAC_BITS));
    localparam logic signed [BW-1:0] OB_HY = BW'(2 ** (FRAC_BITS - 2));

    // register map
    localparam logic [2:0] REG_STEP  = 3'd0;
    localparam logic [2:0] REG_ROOTX = 3'd1;
    localparam logic [2:0] REG_ROOTY = 3'd2;
    localparam logic [2:0] REG_GOALX = 3'd3;
    localparam logic [2:0] REG_GOALY = 3'd4;
    localparam logic [2:0] REG_TOL   = 3'd5;
    localparam logic [2:0] REG_CLR   = 3'd6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SQRT  = 4'd2;
    localparam logic [3:0] S_MULT  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_FINAL = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    // configuration registers
    logic [14:0]        r_step;
    logic signed [15:0] r_root_x, r_root_y, r_goal_x, r_goal_y;
    logic [14:0]        r_tol, r_clr;

    // node memory: {x, y, parent}
    logic [EW-1:0]      r_mem [MAX_NODES];
    logic [EW-1:0]      r_rd_data;
    logic [NW-1:0]      w_rd_addr;
    logic               w_rd_en;
    logic               w_wr_en;

    logic [3:0]         r_state;
    logic [TW-1:0]      r_node_total;
    logic               r_goal_done;
    logic signed [15:0] r_sx, r_sy;
    logic [9:0]         r_sel;
    logic [5:0]         r_cnt;

    // scan pipeline
    logic [TW-1:0]      r_rd_idx;
    logic               r_p1_vld, r_p2_vld;
    logic [NW-1:0]      r_p1_idx, r_p2_idx;
    logic [33:0]        r_p2_sqx, r_p2_sqy;
    logic signed [15:0] r_p2_x, r_p2_y;
    logic [34:0]        r_bestd;
    logic [NW-1:0]      r_best_idx;
    logic signed [15:0] r_bx, r_by;

    // root and divide
    logic [63:0]        r_rad;
    logic [31:0]        r_root;
    logic [33:0]        r_srem;
    logic               r_negx, r_negy;
    logic [15:0]        r_magx, r_magy;
    logic [30:0]        r_prodx, r_prody;
    logic [46:0]        r_dqx, r_dqy;
    logic [32:0]        r_drx, r_dry;
    logic signed [15:0] r_nx, r_ny;
    logic               r_blk;
    logic [33:0]        r_gsqx, r_gsqy;
    logic [29:0]        r_tsq;

    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_vld;

    // combinational helpers
    logic signed [15:0] w_cx, w_cy;
    logic signed [16:0] w_dx, w_dy;
    logic signed [33:0] w_sqx, w_sqy;
    logic [34:0]        w_d;
    logic [33:0]        w_rsh, w_trial;
    logic [32:0]        w_dshx, w_dshy;
    logic signed [34:0] w_sumx, w_sumy;
    logic               w_blocked;
    logic signed [16:0] w_gdx, w_gdy;
    logic signed [33:0] w_gsx, w_gsy;
    logic               w_cfg_wr;
    logic [2:0]         w_reg;
    logic               w_accept;

    function automatic logic f_in_box(input logic signed [BW-1:0] px,
                                      input logic signed [BW-1:0] py,
                                      input logic signed [BW-1:0] cx,
                                      input logic signed [BW-1:0] cy,
                                      input logic signed [BW-1:0] hx,
                                      input logic signed [BW-1:0] hy);
        logic signed [BW-1:0] ex, ey;
        begin
            ex = cx - px;
            ey = cy - py;
            if (ex < 0) ex = -ex;
            if (ey < 0) ey = -ey;
            return (ex <= hx) && (ey <= hy);
        end
    endfunction

    function automatic logic signed [15:0] f_sat(input logic signed [34:0] v);
        if (v > 35'sd32767) return 16'sh7fff;
        else if (v < -35'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    // apb
    assign pready   = 1'b1;
    assign w_reg    = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            REG_STEP:  prdata = {17'd0, r_step};
            REG_ROOTX: prdata = {{16{r_root_x[15]}}, r_root_x};
            REG_ROOTY: prdata = {{16{r_root_y[15]}}, r_root_y};
            REG_GOALX: prdata = {{16{r_goal_x[15]}}, r_goal_x};
            REG_GOALY: prdata = {{16{r_goal_y[15]}}, r_goal_y};
            REG_TOL:   prdata = {17'd0, r_tol};
            REG_CLR:   prdata = {17'd0, r_clr};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 15'd205;
            r_root_x <= 16'sd3072;
            r_root_y <= -16'sd3072;
            r_goal_x <= 16'sd4096;
            r_goal_y <= 16'sd4096;
            r_tol    <= 15'd205;
            r_clr    <= 15'd162;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_STEP:  r_step   <= pwdata[14:0];
                REG_ROOTX: r_root_x <= pwdata[15:0];
                REG_ROOTY: r_root_y <= pwdata[15:0];
                REG_GOALX: r_goal_x <= pwdata[15:0];
                REG_GOALY: r_goal_y <= pwdata[15:0];
                REG_TOL:   r_tol    <= pwdata[14:0];
                REG_CLR:   r_clr    <= pwdata[14:0];
                default:   ;
            endcase
        end
    end

    // request channel
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // memory port: reads for scan and readback, one write per stored node
    always_comb begin
        w_rd_addr = r_rd_idx[NW-1:0];
        w_rd_en   = (r_state == S_SCAN) && (r_rd_idx < r_node_total);
        if (r_state == S_IDLE) begin
            w_rd_addr = NW'(i_req.data.node_select);
            w_rd_en   = w_accept;
        end
    end
    assign w_wr_en = (r_state == S_FINAL) && !r_blk;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_node_total[NW-1:0]] <= {r_nx, r_ny, r_best_idx};
        if (w_rd_en) r_rd_data <= r_mem[w_rd_addr];
    end

    // scan stage 1: distance components of the node just read
    assign w_cx  = (r_p1_idx == '0) ? r_root_x : r_rd_data[EW-1 -: 16];
    assign w_cy  = (r_p1_idx == '0) ? r_root_y : r_rd_data[EW-17 -: 16];
    assign w_dx  = 17'(w_cx) - 17'(r_sx);
    assign w_dy  = 17'(w_cy) - 17'(r_sy);
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;
    assign w_d   = 35'(r_p2_sqx) + 35'(r_p2_sqy);

    // one root digit per cycle
    assign w_rsh   = {r_srem[31:0], r_rad[63:62]};
    assign w_trial = {r_root, 2'b01};

    // one quotient bit per cycle, both axes
    assign w_dshx = {r_drx[31:0], r_dqx[46]};
    assign w_dshy = {r_dry[31:0], r_dqy[46]};

    // new point before saturation
    assign w_sumx = 35'(r_bx) + (r_negx ? -$signed({2'b00, r_dqx[32:0]})
                                        : $signed({2'b00, r_dqx[32:0]}));
    assign w_sumy = 35'(r_by) + (r_negy ? -$signed({2'b00, r_dqy[32:0]})
                                        : $signed({2'b00, r_dqy[32:0]}));

    // obstacle test and goal distance on the saturated point
    always_comb begin
        logic signed [BW-1:0] px, py, hx, hy;
        px = BW'(r_nx);
        py = BW'(r_ny);
        hx = OB_HX + BW'(r_clr);
        hy = OB_HY + BW'(r_clr);
        w_blocked = f_in_box(px, py, OB_C, OB_C, hx, hy)
                 || f_in_box(px, py, -OB_C, '0, hx, hy)
                 || f_in_box(px, py, OB_C, -OB_C, hx, hy);
    end
    assign w_gdx = 17'(r_nx) - 17'(r_goal_x);
    assign w_gdy = 17'(r_ny) - 17'(r_goal_y);
    assign w_gsx = w_gdx * w_gdx;
    assign w_gsy = w_gdy * w_gdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_total <= TW'(1);
            r_goal_done  <= 1'b0;
            r_out_vld    <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // a response leaving with nothing to replace it
            if (r_out_vld && o_rsp.ready && (r_state != S_EMIT)) r_out_vld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sx  <= i_req.data.sample_x;
                        r_sy  <= i_req.data.sample_y;
                        r_sel <= i_req.data.node_select;
                        if (i_req.data.op == OP_READ) begin
                            r_res   <= '0;
                            r_state <= S_RDW;
                        end else if (r_goal_done) begin
                            r_res   <= {ST_DONE, (RW-3)'(0)};
                            r_state <= S_EMIT;
                        end else if (r_node_total >= TW'(MAX_NODES)) begin
                            r_res   <= {ST_FULL, (RW-3)'(0)};
                            r_state <= S_EMIT;
                        end else begin
                            r_res    <= '0;
                            r_rd_idx <= '0;
                            r_p1_vld <= 1'b0;
                            r_p2_vld <= 1'b0;
                            r_bestd  <= '1;
                            r_state  <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // issue
                    r_p1_vld <= w_rd_en;
                    r_p1_idx <= r_rd_idx[NW-1:0];
                    if (w_rd_en) r_rd_idx <= r_rd_idx + TW'(1);
                    // squares
                    r_p2_vld <= r_p1_vld;
                    r_p2_idx <= r_p1_idx;
                    r_p2_sqx <= $unsigned(w_sqx);
                    r_p2_sqy <= $unsigned(w_sqy);
                    r_p2_x   <= w_cx;
                    r_p2_y   <= w_cy;
                    // keep the first strictly smaller distance
                    if (r_p2_vld && (w_d < r_bestd)) begin
                        r_bestd    <= w_d;
                        r_best_idx <= r_p2_idx;
                        r_bx       <= r_p2_x;
                        r_by       <= r_p2_y;
                    end
                    if (!w_rd_en && !r_p1_vld && !r_p2_vld) begin
                        if (r_bestd == '0 || r_step == '0) begin
                            r_res.status <= ST_ZERO;
                            r_state      <= S_EMIT;
                        end else begin
                            r_rad   <= {r_bestd[33:0], 30'd0};
                            r_root  <= '0;
                            r_srem  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end
                    end
                end

                S_SQRT: begin
                    r_rad <= {r_rad[61:0], 2'b00};
                    if (w_rsh >= w_trial) begin
                        r_srem <= w_rsh - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_srem <= w_rsh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_negx  <= (r_sx < r_bx);
                        r_negy  <= (r_sy < r_by);
                        r_magx  <= (r_sx < r_bx) ? 16'(17'(r_bx) - 17'(r_sx))
                                                 : 16'(17'(r_sx) - 17'(r_bx));
                        r_magy  <= (r_sy < r_by) ? 16'(17'(r_by) - 17'(r_sy))
                                                 : 16'(17'(r_sy) - 17'(r_by));
                        r_state <= S_MULT;
                    end
                end

                S_MULT: begin
                    r_prodx <= r_magx * r_step;
                    r_prody <= r_magy * r_step;
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                    r_drx   <= '0;
                    r_dry   <= '0;
                end

                S_DIV: begin
                    // numerator with half the divisor added for rounding
                    if (r_cnt == 6'd0) begin
                        r_dqx <= {1'b0, r_prodx, 15'd0} + 47'(r_root[31:1]);
                        r_dqy <= {1'b0, r_prody, 15'd0} + 47'(r_root[31:1]);
                        r_cnt <= 6'd1;
                    end else begin
                        if (w_dshx >= {1'b0, r_root}) begin
                            r_drx <= w_dshx - {1'b0, r_root};
                            r_dqx <= {r_dqx[45:0], 1'b1};
                        end else begin
                            r_drx <= w_dshx;
                            r_dqx <= {r_dqx[45:0], 1'b0};
                        end
                        if (w_dshy >= {1'b0, r_root}) begin
                            r_dry <= w_dshy - {1'b0, r_root};
                            r_dqy <= {r_dqy[45:0], 1'b1};
                        end else begin
                            r_dry <= w_dshy;
                            r_dqy <= {r_dqy[45:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd47) r_state <= S_ADD;
                    end
                end

                S_ADD: begin
                    r_nx    <= f_sat(w_sumx);
                    r_ny    <= f_sat(w_sumy);
                    r_state <= S_CHECK;
                end

                S_CHECK: begin
                    r_blk   <= w_blocked;
                    r_gsqx  <= $unsigned(w_gsx);
                    r_gsqy  <= $unsigned(w_gsy);
                    r_tsq   <= r_tol * r_tol;
                    r_state <= S_FINAL;
                end

                S_FINAL: begin
                    if (r_blk) begin
                        r_res.status <= ST_BLOCKED;
                    end else begin
                        r_res.status       <= ST_OK;
                        r_res.node_index   <= 10'(r_node_total[NW-1:0]);
                        r_res.node_x       <= r_nx;
                        r_res.node_y       <= r_ny;
                        r_res.parent_index <= 10'(r_best_idx);
                        r_node_total       <= r_node_total + TW'(1);
                        if (35'(r_gsqx) + 35'(r_gsqy) <= 35'(r_tsq)) r_goal_done <= 1'b1;
                    end
                    r_state <= S_EMIT;
                end

                S_RDW: begin
                    if (17'(r_sel) >= 17'(r_node_total)) begin
                        r_res.status <= ST_BADIDX;
                    end else begin
                        r_res.status     <= ST_OK;
                        r_res.node_index <= r_sel;
                        if (r_sel == '0) begin
                            r_res.node_x       <= r_root_x;
                            r_res.node_y       <= r_root_y;
                            r_res.parent_index <= '0;
                        end else begin
                            r_res.node_x       <= r_rd_data[EW-1 -: 16];
                            r_res.node_y       <= r_rd_data[EW-17 -: 16];
                            r_res.parent_index <= 10'(r_rd_data[NW-1:0]);
                        end
                    end
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    // wait for the output register to free up
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out     <= {r_res[RW-1:1], r_goal_done};
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // node count stays within the store
    `RTE_ASSERT_ALWAYS(a_total_range, (r_node_total >= TW'(1)) && (r_node_total <= TW'(MAX_NODES)))
    // a node is only appended while there is room
    `RTE_ASSERT_ALWAYS(a_write_room, !w_wr_en || (r_node_total < TW'(MAX_NODES)))
    // goal flag is sticky
    `RTE_ASSERT_NEXT(a_goal_sticky, r_goal_done, r_goal_done)

endmodule
